@@ src/b64sc_pkg.sv @@
// Shared types, codes and symbol tables for the base64 stream codec.
// No dependencies; every other file of the block imports this package.
package b64sc_pkg;

    // Job queue between the front and back halves.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One job expands into at most five result beats.
    localparam int BEAT_W = 3;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        CMD_DATA  = 2'd0,
        CMD_START = 2'd1,
        CMD_END   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_START    = 3'd1,
        KIND_END      = 3'd2,
        KIND_BADSYM   = 3'd3,
        KIND_EARLYEND = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        OP_START,
        OP_END,
        OP_EARLY,
        OP_ENC,
        OP_DEC
    } op_t;

    // A job: what the back half has to emit for one input beat.
    typedef struct packed {
        op_t             op;
        logic [1:0]      cnt;       // bytes held in an encode group
        logic            with_end;  // encode group is followed by an end marker
        logic [3:0][7:0] grp;       // group bytes, slot 0 first
    } job_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sym_t;

    // Maps a 6-bit value to its alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] idx);
        logic [7:0] c;
        c = 8'h2F;
        case (idx) inside
            [6'd0:6'd25]:  c = 8'h41 + {2'b00, idx};
            [6'd26:6'd51]: c = 8'h61 + {2'b00, idx} - 8'd26;
            [6'd52:6'd61]: c = 8'h30 + {2'b00, idx} - 8'd52;
            6'd62:         c = 8'h2B;
            default:       c = 8'h2F;
        endcase
        return c;
    endfunction

    // Maps an alphabet character back to its 6-bit value.
    function automatic sym_t sym_val(input logic [7:0] c);
        sym_t s;
        s = '0;
        case (c) inside
            [8'h41:8'h5A]: s = '{valid: 1'b1, value: 6'(c - 8'h41)};
            [8'h61:8'h7A]: s = '{valid: 1'b1, value: 6'(c - 8'h61 + 8'd26)};
            [8'h30:8'h39]: s = '{valid: 1'b1, value: 6'(c - 8'h30 + 8'd52)};
            8'h2B:         s = '{valid: 1'b1, value: 6'd62};
            8'h2F:         s = '{valid: 1'b1, value: 6'd63};
            default:       s = '0;
        endcase
        return s;
    endfunction

endpackage

@@ src/b64sc_front.sv @@
// Front half of the base64 codec: accepts input beats, gathers groups and
// pushes one job per completed group or marker. Depends on b64sc_pkg.
module b64sc_front
    import b64sc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [7:0] s_data_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_encode_mode,
    output logic       push_valid,
    output job_t       push_job,
    input  logic       q_full
);

    logic            mode_reg, mode_next;
    logic [1:0]      count_reg, count_next;
    logic [3:0][7:0] grp_reg, grp_next;
    logic [3:0][7:0] grp_ins;
    logic            accept;

    // Register writes take priority; the port never holds them off.
    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full && !cfg_valid;
    assign accept    = s_valid && s_ready;

    // Group contents with the incoming byte placed in its slot.
    always_comb begin
        grp_ins            = grp_reg;
        grp_ins[count_reg] = s_data_byte;
    end

    // Group bookkeeping and job formation.
    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        grp_next   = grp_reg;
        push_valid = 1'b0;
        push_job   = '{op: OP_START, cnt: 2'd0, with_end: 1'b0, grp: grp_ins};
        if (cfg_valid) begin
            mode_next  = cfg_encode_mode;
            count_next = 2'd0;
        end else if (accept) begin
            case (cmd_t'(s_command))
                CMD_DATA: begin
                    grp_next = grp_ins;
                    if (mode_reg && count_reg == 2'd2) begin
                        push_valid   = 1'b1;
                        push_job.op  = OP_ENC;
                        push_job.cnt = 2'd3;
                        count_next   = 2'd0;
                    end else if (!mode_reg && count_reg == 2'd3) begin
                        push_valid  = 1'b1;
                        push_job.op = OP_DEC;
                        count_next  = 2'd0;
                    end else begin
                        count_next = count_reg + 2'd1;
                    end
                end
                CMD_START: begin
                    push_valid  = 1'b1;
                    push_job.op = OP_START;
                    count_next  = 2'd0;
                end
                CMD_END: begin
                    push_valid   = 1'b1;
                    push_job.grp = grp_reg;
                    count_next   = 2'd0;
                    if (mode_reg) begin
                        push_job.op       = OP_ENC;
                        push_job.cnt      = count_reg;
                        push_job.with_end = 1'b1;
                    end else if (count_reg != 2'd0) begin
                        push_job.op = OP_EARLY;
                    end else begin
                        push_job.op = OP_END;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b1;
            count_reg <= 2'd0;
        end else begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    // Group bytes need no reset; only written slots are ever read.
    always_ff @(posedge aclk) begin
        grp_reg <= grp_next;
    end

endmodule

@@ src/b64sc_queue.sv @@
// Short job queue that decouples the front and back halves of the codec.
// Depends on b64sc_pkg for the job type and depth.
module b64sc_queue
    import b64sc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    input  job_t push_job,
    output logic q_full,
    input  logic pop,
    output logic q_valid,
    output job_t q_job
);

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_full  = count_reg == QCNT_W'(QDEPTH);
    assign q_valid = count_reg != '0;
    assign q_job   = mem_reg[rd_ptr_reg];
    assign do_push = push_valid && !q_full;
    assign do_pop  = pop && q_valid;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ src/b64sc_back.sv @@
// Back half of the base64 codec (needs b64sc_pkg): turns the queue-head job into
// result beats through an output register, one per cycle unless m_ready stalls.
module b64sc_back
    import b64sc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_out_byte,
    output logic       m_last
);

    logic [BEAT_W-1:0] idx_reg, idx_next;
    logic              m_valid_reg, m_valid_next;
    kind_t             m_kind_reg;
    logic [7:0]        m_out_byte_reg;
    logic              m_last_reg;

    logic [BEAT_W-1:0] n_beats;
    logic              beat_last, adv;
    kind_t             beat_kind;
    logic [7:0]        beat_byte;

    logic [7:0]        b0, b1, b2;
    logic [7:0]        c0, c1, c2, c3;
    logic [BEAT_W-1:0] enc_base;
    sym_t              s0, s1, s2, s3;
    logic              pad2, pad3, bad;
    logic [7:0]        d0, d1, d2;

    // Encode: split the group into four 6-bit indexes; missing bytes are zero.
    always_comb begin
        b0       = q_job.grp[0];
        b1       = (q_job.cnt > 2'd1) ? q_job.grp[1] : 8'd0;
        b2       = (q_job.cnt > 2'd2) ? q_job.grp[2] : 8'd0;
        c0       = enc_char(b0[7:2]);
        c1       = enc_char({b0[1:0], b1[7:4]});
        c2       = (q_job.cnt > 2'd1) ? enc_char({b1[3:0], b2[7:6]}) : PAD_CHAR;
        c3       = (q_job.cnt > 2'd2) ? enc_char(b2[5:0]) : PAD_CHAR;
        enc_base = (q_job.cnt != 2'd0) ? BEAT_W'(4) : BEAT_W'(0);
    end

    // Decode: look up the four symbols and check the padding pattern.
    always_comb begin
        s0   = sym_val(q_job.grp[0]);
        s1   = sym_val(q_job.grp[1]);
        s2   = sym_val(q_job.grp[2]);
        s3   = sym_val(q_job.grp[3]);
        pad2 = q_job.grp[2] == PAD_CHAR;
        pad3 = q_job.grp[3] == PAD_CHAR;
        bad  = (pad2 && !pad3) || !s0.valid || !s1.valid
            || (!pad2 && !s2.valid) || (!pad3 && !s3.valid);
        d0   = {s0.value, s1.value[5:4]};
        d1   = {s1.value[3:0], s2.value[5:2]};
        d2   = {s2.value[1:0], s3.value};
    end

    // Beat count and content for the current position within the job.
    always_comb begin
        n_beats   = BEAT_W'(1);
        beat_kind = KIND_DATA;
        beat_byte = 8'd0;
        case (q_job.op)
            OP_START: beat_kind = KIND_START;
            OP_END:   beat_kind = KIND_END;
            OP_EARLY: beat_kind = KIND_EARLYEND;
            OP_ENC: begin
                n_beats = enc_base + BEAT_W'(q_job.with_end);
                if (idx_reg < enc_base) begin
                    case (idx_reg[1:0])
                        2'd0:    beat_byte = c0;
                        2'd1:    beat_byte = c1;
                        2'd2:    beat_byte = c2;
                        default: beat_byte = c3;
                    endcase
                end else begin
                    beat_kind = KIND_END;
                end
            end
            OP_DEC: begin
                if (bad) begin
                    beat_kind = KIND_BADSYM;
                end else begin
                    n_beats = pad2 ? BEAT_W'(1) : (pad3 ? BEAT_W'(2) : BEAT_W'(3));
                    case (idx_reg[1:0])
                        2'd0:    beat_byte = d0;
                        2'd1:    beat_byte = d1;
                        default: beat_byte = d2;
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // One beat moves into the output register whenever it is free or drains.
    always_comb begin
        adv          = q_valid && (!m_valid_reg || m_ready);
        beat_last    = idx_reg == n_beats - BEAT_W'(1);
        pop          = adv && beat_last;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (adv) begin
            idx_next     = beat_last ? '0 : idx_reg + BEAT_W'(1);
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload holds while the beat waits.
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_kind_reg     <= beat_kind;
            m_out_byte_reg <= beat_byte;
            m_last_reg     <= beat_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_last     = m_last_reg;

    // The beat position never runs past the job's beat count.
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> idx_reg < n_beats)
        else $error("beat index beyond job length");

    // A beat that is not the last keeps the job and steps the position by one.
    a_idx_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !beat_last |=> q_valid && idx_reg == $past(idx_reg) + BEAT_W'(1))
        else $error("job lost or position skipped");

    // Start, end and early-end marker jobs always come as a single beat.
    a_marker_single: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && (q_job.op == OP_START || q_job.op == OP_END || q_job.op == OP_EARLY)
        |-> beat_last && idx_reg == '0)
        else $error("marker job spans more than one beat");

endmodule

@@ src/base64_stream_codec_core.sv @@
// Base64 stream codec top level: input front half, job queue, output back half.
// Depends on b64sc_pkg, b64sc_front, b64sc_queue and b64sc_back.
//
// The core takes one input beat per cycle while its two-entry job queue has
// room and no mode write is pending, and delivers one result beat per cycle
// through a registered output while m_ready allows. A completed group or a
// marker becomes one job of one to five result beats, so the sustained input
// rate is set by the output port: an encode group of three bytes gives four
// result beats, a decode group of four characters at most three. Writes to
// the mode register are taken at any time and clear the current group; they
// are meant for idle periods.
module base64_stream_codec_core
    import b64sc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_out_byte,
    output logic       m_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_encode_mode
);

    logic push_valid;
    job_t push_job;
    logic q_full;
    logic q_valid;
    job_t q_job;
    logic pop;

    // Group gathering and job formation.
    b64sc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_data_byte     (s_data_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_encode_mode (cfg_encode_mode),
        .push_valid      (push_valid),
        .push_job        (push_job),
        .q_full          (q_full)
    );

    // Job queue.
    b64sc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .q_full     (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_job      (q_job)
    );

    // Result beat generation.
    b64sc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_job      (q_job),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for base64_stream_codec_core: directed and random byte and text streams
// in both modes, with a scoreboard that predicts every result beat. Depends on b64sc_pkg and
// the core RTL.

import b64sc_pkg::*;

// Predicts the result beats of each accepted input beat and checks the output against them.
class codec_scoreboard;
    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       last;
    } beat_t;

    string       symbols = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    bit          encoding;
    logic [7:0]  grp [4];
    int unsigned fill;
    beat_t       due_beats [$];
    beat_t       batch [$];
    int          errors;

    function new();
        encoding = 1'b1;
        fill = 0;
        errors = 0;
    endfunction

    function logic [7:0] char_of(logic [5:0] idx);
        return symbols[idx];
    endfunction

    // Returns the 6-bit value of an alphabet character, or -1 if it is not in the alphabet.
    function int value_of(logic [7:0] c);
        for (int i = 0; i < 64; i++)
            if (symbols[i] == c) return i;
        return -1;
    endfunction

    function void complain(string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endfunction

    function void emit(kind_t k, logic [7:0] v);
        beat_t b;
        b.kind = k;
        b.value = v;
        b.last = 1'b0;
        batch.push_back(b);
    endfunction

    // A mode write always drops the group in progress.
    function void write_mode(bit enc);
        encoding = enc;
        fill = 0;
    endfunction

    // Turns the held bytes into four characters; missing bytes count as zero and become pads.
    function void encode_group();
        logic [7:0] b0, b1, b2;
        if (fill == 0) return;
        b0 = grp[0];
        b1 = (fill > 1) ? grp[1] : 8'h00;
        b2 = (fill > 2) ? grp[2] : 8'h00;
        emit(KIND_DATA, char_of(b0[7:2]));
        emit(KIND_DATA, char_of({b0[1:0], b1[7:4]}));
        emit(KIND_DATA, (fill > 1) ? char_of({b1[3:0], b2[7:6]}) : PAD_CHAR);
        emit(KIND_DATA, (fill > 2) ? char_of(b2[5:0]) : PAD_CHAR);
        fill = 0;
    endfunction

    // Turns four held characters into one to three bytes, or one invalid-symbol beat.
    function void decode_group();
        int v [4];
        int used;
        bit pad2, pad3;
        pad3 = (grp[3] == PAD_CHAR);
        pad2 = (grp[2] == PAD_CHAR);
        fill = 0;
        if (pad2 && !pad3) begin
            emit(KIND_BADSYM, 8'h00);
            return;
        end
        used = pad3 ? (pad2 ? 2 : 3) : 4;
        for (int i = 0; i < used; i++) begin
            v[i] = value_of(grp[i]);
            if (v[i] < 0) begin
                emit(KIND_BADSYM, 8'h00);
                return;
            end
        end
        emit(KIND_DATA, 8'((v[0] << 2) | (v[1] >> 4)));
        if (used > 2) emit(KIND_DATA, 8'((v[1] << 4) | (v[2] >> 2)));
        if (used > 3) emit(KIND_DATA, 8'((v[2] << 6) | v[3]));
    endfunction

    // Called for every accepted input beat; queues the result beats it will cause.
    function void take_item(cmd_t cmd, logic [7:0] b);
        batch.delete();
        case (cmd)
            CMD_DATA: begin
                grp[fill % 4] = b;
                fill = (fill + 1) % 8;
                if (encoding && fill >= 3)
                    encode_group();
                else if (!encoding && fill >= 4)
                    decode_group();
            end
            CMD_START: begin
                fill = 0;
                emit(KIND_START, 8'h00);
            end
            CMD_END: begin
                if (encoding) begin
                    encode_group();
                    emit(KIND_END, 8'h00);
                end else if (fill != 0) begin
                    fill = 0;
                    emit(KIND_EARLYEND, 8'h00);
                end else begin
                    emit(KIND_END, 8'h00);
                end
            end
            CMD_NONE: ;
        endcase
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) due_beats.push_back(batch[i]);
    endfunction

    // Called for every accepted result beat; compares it with the oldest prediction.
    function void check_beat(logic [2:0] kind, logic [7:0] value, logic last);
        beat_t want;
        if (due_beats.size() == 0) begin
            complain($sformatf("unexpected result: kind %0d byte %02h last %0b",
                               kind, value, last));
            return;
        end
        want = due_beats.pop_front();
        if (kind !== want.kind || value !== want.value || last !== want.last)
            complain($sformatf("mismatch: expected kind %0d byte %02h last %0b, got %0d %02h %0b",
                               want.kind, want.value, want.last, kind, value, last));
    endfunction

    function int pending();
        return due_beats.size();
    endfunction

    function bit clean();
        return (errors == 0) && (due_beats.size() == 0);
    endfunction
endclass

module tb_top;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_GAP        = 20;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_command = CMD_DATA;
    logic [7:0] s_data_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_kind;
    logic [7:0] m_out_byte;
    logic       m_last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_encode_mode = 1'b1;

    codec_scoreboard sb = new();
    bit mode_now = 1'b1;
    bit calm = 1'b0;
    int sent = 0;
    int quiet = 0;

    base64_stream_codec_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_out_byte      (m_out_byte),
        .m_last          (m_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_encode_mode (cfg_encode_mode)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // The result side stalls at random, except during the calm stretch.
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= calm || ($urandom_range(99) >= 27);
    end

    // Observe every handshake on the pre-edge values, and stop a run that stalls.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_mode(cfg_encode_mode);
            if (s_valid && s_ready) sb.take_item(cmd_t'(s_command), s_data_byte);
            if (m_valid && m_ready) sb.check_beat(m_kind, m_out_byte, m_last);
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("[base64_stream_codec_core] ERROR");
                $finish;
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic int idle_gap();
        int gap;
        gap = 0;
        while (!calm && gap < MAX_GAP && $urandom_range(99) < 27) gap++;
        return gap;
    endfunction

    // Offers one input beat and holds it until the core takes it.
    task automatic push(input cmd_t cmd, input logic [7:0] b);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (cmd != CMD_NONE) sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push(CMD_DATA, s[i]);
    endtask

    // Stops the input and waits until every predicted beat has come out.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_mode(input bit enc);
        drain();
        cfg_valid <= 1'b1;
        cfg_encode_mode <= enc;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        mode_now = enc;
    endtask

    // A byte stream between markers; now and then the end marker is left out.
    task automatic enc_frame();
        int n;
        n = $urandom_range(0, 10);
        push(CMD_START, rand_byte());
        repeat (n) push(CMD_DATA, rand_byte());
        if ($urandom_range(9) != 0) push(CMD_END, rand_byte());
    endtask

    // Well-formed text of random bytes, sometimes with one damaged character or a cut tail.
    task automatic dec_frame();
        logic [7:0] raw [$];
        logic [7:0] txt [$];
        logic [7:0] b0, b1, b2;
        int n, left, spot, cut;
        n = $urandom_range(0, 9);
        repeat (n) raw.push_back(rand_byte());
        for (int k = 0; k < n; k += 3) begin
            left = n - k;
            b0 = raw[k];
            b1 = (left > 1) ? raw[k + 1] : 8'h00;
            b2 = (left > 2) ? raw[k + 2] : 8'h00;
            txt.push_back(sb.char_of(b0[7:2]));
            txt.push_back(sb.char_of({b0[1:0], b1[7:4]}));
            txt.push_back((left > 1) ? sb.char_of({b1[3:0], b2[7:6]}) : PAD_CHAR);
            txt.push_back((left > 2) ? sb.char_of(b2[5:0]) : PAD_CHAR);
        end
        if (txt.size() > 0 && $urandom_range(4) == 0) begin
            spot = $urandom_range(txt.size() - 1);
            case ($urandom_range(2))
                0: txt[spot] = rand_byte();
                1: txt[spot] = PAD_CHAR;
                default: txt[spot] = sb.char_of(6'($urandom_range(63)));
            endcase
        end
        cut = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0;
        push(CMD_START, rand_byte());
        for (int i = 0; i + cut < txt.size(); i++) push(CMD_DATA, txt[i]);
        push(CMD_END, rand_byte());
    endtask

    // Loose beats of any command, with pads and stray characters mixed in.
    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) begin
            case ($urandom_range(9))
                0: push(CMD_START, rand_byte());
                1: push(CMD_END, rand_byte());
                2: push(CMD_NONE, rand_byte());
                3, 4: push(CMD_DATA, PAD_CHAR);
                5, 6: push(CMD_DATA, rand_byte());
                default: push(CMD_DATA, sb.char_of(6'($urandom_range(63))));
            endcase
        end
    endtask

    initial begin
        int goal;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Encoding after reset: a full group, both flush lengths, an empty end.
        push(CMD_START, 8'hFF);
        push(CMD_DATA, 8'h00);
        push(CMD_DATA, 8'hFF);
        push(CMD_DATA, 8'h80);
        push(CMD_DATA, 8'h01);
        push(CMD_NONE, 8'hFF);
        push(CMD_END, 8'h00);
        push(CMD_DATA, 8'hAA);
        push(CMD_DATA, 8'h55);
        push(CMD_END, 8'h7F);
        push(CMD_END, 8'h00);
        // This byte stays in the group; the mode write must drop it.
        push(CMD_DATA, 8'h7E);
        set_mode(1'b0);

        // Decoding: alphabet ends, one and two pads, a misplaced pad, an early end.
        push(CMD_START, 8'h00);
        push_text("+/z9");
        push_text("TQ==");
        push_text("TWE=");
        push_text("AB=C");
        push_text("AB");
        push(CMD_END, 8'h00);
        push(CMD_END, 8'h00);

        // Random phases in alternating modes; one phase runs with no idling on either side.
        for (int phase = 0; phase < 6; phase++) begin
            set_mode(phase % 2 == 0);
            calm = (phase == 3);
            goal = sent + 62;
            while (sent < goal) begin
                if ($urandom_range(99) < 75) begin
                    if (mode_now)
                        enc_frame();
                    else
                        dec_frame();
                end else begin
                    noise_burst();
                end
            end
        end
        calm = 1'b0;

        drain();
        if (sb.clean())
            $display("[base64_stream_codec_core] OK");
        else
            $display("[base64_stream_codec_core] ERROR");
        $finish;
    end
endmodule

@@ files.f @@
src/b64sc_pkg.sv
src/b64sc_front.sv
src/b64sc_queue.sv
src/b64sc_back.sv
src/base64_stream_codec_core.sv
bench/tb_top.sv
